FILE: src/feasible_dvfs_level_search_top_assert.svh
// ----------------------------------------------------------------------------
// Feasible DVFS level search assertion macros
// Concurrent property wrappers shared by the RTL of the level search block.
// ----------------------------------------------------------------------------
`ifndef FEASIBLE_DVFS_LEVEL_SEARCH_TOP_ASSERT_SVH
`define FEASIBLE_DVFS_LEVEL_SEARCH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDLS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/fdls_pkg.sv
// ----------------------------------------------------------------------------
// Feasible DVFS level search package
// Field widths, register map, reset values and unit interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package fdls_pkg;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 4;
	localparam int LEVEL_W   = 4;
	localparam int FREQ_W    = 22;
	localparam int RT_W      = 20;
	localparam int TS_W      = 5;
	localparam int TGT_W     = 20;
	localparam int MARGIN_W  = 11;
	localparam int FACTOR_W  = 11;
	localparam int FNEXT_W   = 23;
	localparam int TICKS_W   = FREQ_W + RT_W;
	localparam int LEVEL_CAP = 16;
	localparam int DEFAULT_TABLE_DEPTH = 16;

	localparam logic [FACTOR_W-1:0] PERMILLE = 11'd1000;
	localparam logic [FREQ_W-1:0]   FREQ_MAX = 22'h3FFFFF;

	localparam logic [TS_W-1:0]     RST_TABLE_SIZE = 5'd1;
	localparam logic [TGT_W-1:0]    RST_TARGET     = 20'd16666;
	localparam logic [MARGIN_W-1:0] RST_MARGIN     = 11'd0;

	localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
	localparam logic [1:0] REG_TARGET     = 2'd1;
	localparam logic [1:0] REG_MARGIN     = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_SET    = 2'd1,
		OP_REPORT = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef struct packed {
		logic              start;
		logic [FREQ_W-1:0] a;
		logic [RT_W-1:0]   b;
	} mul_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [TICKS_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic               start;
		logic [TICKS_W-1:0] dividend;
		logic [FNEXT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [TICKS_W-1:0] q;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: src/fdls_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/fdls_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdls_mul
	import fdls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int CNT_W = $clog2(RT_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [FREQ_W-1:0]  a_q;
	logic [TICKS_W-1:0] p_q;
	logic [FREQ_W:0]    sum;

	assign sum = {1'b0, p_q[TICKS_W-1:RT_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			p_q <= {{FREQ_W{1'b0}}, req.b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[RT_W-1:1]};
		end
	end

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		rsp.p    = p_q;
	end

endmodule

`default_nettype wire

FILE: src/fdls_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdls_div
	import fdls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(TICKS_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [FNEXT_W-1:0] rem_q;
	logic [FNEXT_W-1:0] dvs_q;
	logic [TICKS_W-1:0] quo_q;
	logic [FNEXT_W:0]   shifted;
	logic [FNEXT_W+1:0] diff;
	logic               fits;

	assign shifted = {rem_q, quo_q[TICKS_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = !diff[FNEXT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TICKS_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[FNEXT_W-1:0] : shifted[FNEXT_W-1:0];
			quo_q <= {quo_q[TICKS_W-2:0], fits};
		end
	end

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		rsp.q    = quo_q;
	end

endmodule

`default_nettype wire

FILE: src/feasible_dvfs_level_search_top.sv
// ----------------------------------------------------------------------------
// Feasible DVFS level search
// Frequency table, current level and the query walk for one clock domain.
// ----------------------------------------------------------------------------
// The block handles one item at a time. A load or set is decoded and its result
// registered for output. A frequency report reads table entries one at a time,
// first downward and then upward from the current level, until it finds the
// level. A query first forms the tick count on the bit-serial multiplier, then
// for every level it visits runs a serial multiply for the derating and two
// serial divides, one by the permille constant and one for the new estimate;
// the second divide is skipped when the first quotient is zero. The result sits
// in an output register, so the next item is taken while it waits.
`default_nettype none

`include "feasible_dvfs_level_search_top_assert.svh"

module feasible_dvfs_level_search_top
	import fdls_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    op,
	input  logic [IDX_W-1:0]   index,
	input  logic [FREQ_W-1:0]  freq_khz,
	input  logic [RT_W-1:0]    render_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FREQ_W-1:0]  next_freq,
	output logic [LEVEL_W-1:0] level,
	output logic               status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [TS_W-1:0] N_CAP =
		TS_W'((TABLE_DEPTH < LEVEL_CAP) ? TABLE_DEPTH : LEVEL_CAP);
	localparam logic signed [MARGIN_W:0] PM_POS = 12'sd1000;
	localparam logic signed [MARGIN_W:0] PM_NEG = -12'sd1000;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_RPT_DN,
		S_RPT_DN_W,
		S_RPT_DN_RD,
		S_RPT_UP,
		S_RPT_UP_W,
		S_RPT_UP_RD,
		S_Q_FETCH,
		S_Q_TICKS,
		S_Q_TICKS_W,
		S_DN_CHK,
		S_UP_CHK,
		S_D_FETCH,
		S_D_MUL,
		S_D_MUL_W,
		S_D_DIV1_W,
		S_D_DIV2_W,
		S_FINISH
	} state_t;

	logic [TS_W-1:0]     table_size_q;
	logic [TGT_W-1:0]    target_q;
	logic [MARGIN_W-1:0] margin_q;

	state_t              state_q;
	op_t                 op_q;
	logic [IDX_W-1:0]    idx_q;
	logic [FREQ_W-1:0]   f_q;
	logic [RT_W-1:0]     rt_q;
	logic [LEVEL_W-1:0]  cl_q;
	logic [TS_W-1:0]     i_q;
	logic [TS_W-1:0]     addr_q;
	logic [TICKS_W-1:0]  ticks_q;
	logic [TICKS_W-1:0]  est_q;
	logic [FNEXT_W-1:0]  fnext_q;
	logic                dir_dn_q;
	logic [FREQ_W-1:0]   rs_freq_q;
	logic                rs_status_q;
	logic                out_valid_q;
	logic [FREQ_W-1:0]   next_freq_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                status_q;
	mul_req_t            mul_req_q;
	div_req_t            div_req_q;

	mul_rsp_t            mul_rsp;
	div_rsp_t            div_rsp;
	logic [TS_W-1:0]     n;
	logic [TS_W-1:0]     start_lv;
	logic [FREQ_W-1:0]   ram_rdata;
	logic                ram_we;
	logic                in_xfer;
	logic                cfg_wr;
	logic signed [MARGIN_W:0] m_ext;
	logic signed [MARGIN_W:0] m_sat;
	logic [FACTOR_W-1:0] factor;
	logic [FREQ_W-1:0]   fnext_sat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	assign n        = (table_size_q < N_CAP) ? table_size_q : N_CAP;
	assign start_lv = ({1'b0, cl_q} >= n) ? (n - 1'b1) : {1'b0, cl_q};
	assign ram_we   = in_xfer && (op_t'(op) == OP_LOAD) && ({1'b0, index} < n);

	assign m_ext  = {margin_q[MARGIN_W-1], margin_q};
	assign m_sat  = (m_ext > PM_POS) ? PM_POS : ((m_ext < PM_NEG) ? PM_NEG : m_ext);
	assign factor = FACTOR_W'(PM_POS - m_sat);
	assign fnext_sat = fnext_q[FNEXT_W-1] ? FREQ_MAX : fnext_q[FREQ_W-1:0];

	always_comb begin
		case (paddr[3:2])
			REG_TABLE_SIZE: prdata = 32'(table_size_q);
			REG_TARGET:     prdata = 32'(target_q);
			REG_MARGIN:     prdata = {{(32 - MARGIN_W){margin_q[MARGIN_W-1]}}, margin_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= RST_TABLE_SIZE;
			target_q     <= RST_TARGET;
			margin_q     <= RST_MARGIN;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_TABLE_SIZE: table_size_q <= pwdata[TS_W-1:0];
				REG_TARGET:     target_q     <= pwdata[TGT_W-1:0];
				REG_MARGIN:     margin_q     <= pwdata[MARGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fdls_ram #(
		.WIDTH(FREQ_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(index)),
		.wdata(freq_khz),
		.raddr(AW'(addr_q)),
		.rdata(ram_rdata)
	);

	fdls_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mul_req_q),
		.rsp   (mul_rsp)
	);

	fdls_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req_q),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_LOAD;
			idx_q       <= '0;
			f_q         <= '0;
			rt_q        <= '0;
			cl_q        <= '0;
			i_q         <= '0;
			addr_q      <= '0;
			ticks_q     <= '0;
			est_q       <= '0;
			fnext_q     <= '0;
			dir_dn_q    <= 1'b0;
			rs_freq_q   <= '0;
			rs_status_q <= 1'b0;
			out_valid_q <= 1'b0;
			next_freq_q <= '0;
			level_q     <= '0;
			status_q    <= 1'b0;
			mul_req_q   <= '0;
			div_req_q   <= '0;
		end else begin
			mul_req_q.start <= (state_q == S_Q_TICKS) || (state_q == S_D_MUL);
			div_req_q.start <= ((state_q == S_D_MUL_W) && mul_rsp.done) ||
				((state_q == S_D_DIV1_W) && div_rsp.done && (div_rsp.q != '0));
			if ((state_q == S_FINISH) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q    <= op_t'(op);
						idx_q   <= index;
						f_q     <= freq_khz;
						rt_q    <= render_time;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					rs_freq_q <= '0;
					fnext_q   <= '0;
					case (op_q)
						OP_LOAD: begin
							rs_status_q <= ({1'b0, idx_q} >= n);
							state_q     <= S_FINISH;
						end
						OP_SET: begin
							rs_status_q <= ({1'b0, idx_q} >= n);
							if ({1'b0, idx_q} < n) begin
								cl_q <= idx_q;
							end
							state_q <= S_FINISH;
						end
						OP_REPORT: begin
							rs_status_q <= (n == '0);
							if (n == '0) begin
								state_q <= S_FINISH;
							end else begin
								i_q     <= {1'b0, cl_q};
								state_q <= S_RPT_DN;
							end
						end
						OP_QUERY: begin
							rs_status_q <= (n == '0);
							if ((n != '0) && (target_q != '0)) begin
								i_q     <= start_lv;
								addr_q  <= start_lv;
								est_q   <= TICKS_W'(rt_q);
								state_q <= S_Q_FETCH;
							end else begin
								state_q <= S_FINISH;
							end
						end
						default: begin
							rs_status_q <= 1'b0;
							state_q     <= S_FINISH;
						end
					endcase
				end
				S_RPT_DN: begin
					if (i_q == '0) begin
						state_q <= S_RPT_UP;
					end else if (i_q >= n) begin
						i_q <= i_q - 1'b1;
					end else begin
						addr_q  <= i_q;
						state_q <= S_RPT_DN_W;
					end
				end
				S_RPT_DN_W: begin
					state_q <= S_RPT_DN_RD;
				end
				S_RPT_DN_RD: begin
					if (f_q <= ram_rdata) begin
						state_q <= S_RPT_UP;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= S_RPT_DN;
					end
				end
				S_RPT_UP: begin
					if (i_q >= n) begin
						cl_q    <= LEVEL_W'(n - 1'b1);
						state_q <= S_FINISH;
					end else begin
						addr_q  <= i_q;
						state_q <= S_RPT_UP_W;
					end
				end
				S_RPT_UP_W: begin
					state_q <= S_RPT_UP_RD;
				end
				S_RPT_UP_RD: begin
					if (f_q >= ram_rdata) begin
						cl_q    <= i_q[LEVEL_W-1:0];
						state_q <= S_FINISH;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RPT_UP;
					end
				end
				S_Q_FETCH: begin
					state_q <= S_Q_TICKS;
				end
				S_Q_TICKS: begin
					mul_req_q.a <= ram_rdata;
					mul_req_q.b <= rt_q;
					state_q     <= S_Q_TICKS_W;
				end
				S_Q_TICKS_W: begin
					if (mul_rsp.done) begin
						ticks_q <= mul_rsp.p;
						state_q <= S_DN_CHK;
					end
				end
				S_DN_CHK: begin
					if ((i_q != '0) && (est_q > TICKS_W'(target_q))) begin
						i_q      <= i_q - 1'b1;
						addr_q   <= i_q - 1'b1;
						dir_dn_q <= 1'b1;
						state_q  <= S_D_FETCH;
					end else begin
						state_q <= S_UP_CHK;
					end
				end
				S_UP_CHK: begin
					if ((i_q + 1'b1) < n) begin
						addr_q   <= i_q + 1'b1;
						dir_dn_q <= 1'b0;
						state_q  <= S_D_FETCH;
					end else begin
						rs_freq_q <= fnext_sat;
						state_q   <= S_FINISH;
					end
				end
				S_D_FETCH: begin
					state_q <= S_D_MUL;
				end
				S_D_MUL: begin
					mul_req_q.a <= ram_rdata;
					mul_req_q.b <= RT_W'(factor);
					state_q     <= S_D_MUL_W;
				end
				S_D_MUL_W: begin
					if (mul_rsp.done) begin
						div_req_q.dividend <= mul_rsp.p;
						div_req_q.divisor  <= FNEXT_W'(PERMILLE);
						state_q            <= S_D_DIV1_W;
					end
				end
				S_D_DIV1_W: begin
					if (div_rsp.done) begin
						fnext_q <= div_rsp.q[FNEXT_W-1:0];
						if (div_rsp.q == '0) begin
							rs_freq_q <= '0;
							state_q   <= S_FINISH;
						end else begin
							div_req_q.dividend <= ticks_q;
							div_req_q.divisor  <= div_rsp.q[FNEXT_W-1:0];
							state_q            <= S_D_DIV2_W;
						end
					end
				end
				S_D_DIV2_W: begin
					if (div_rsp.done) begin
						est_q <= div_rsp.q;
						if (dir_dn_q) begin
							state_q <= S_DN_CHK;
						end else if (div_rsp.q < TICKS_W'(target_q)) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_UP_CHK;
						end else begin
							rs_freq_q <= fnext_sat;
							state_q   <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						next_freq_q <= rs_freq_q;
						level_q     <= cl_q;
						status_q    <= rs_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign next_freq = next_freq_q;
	assign level     = level_q;
	assign status    = status_q;

	`FDLS_ASSERT_NEXT(a_busy_after_xfer, clk, arst_n, in_xfer, !in_ready,
		"input taken while an item is in progress")
	`FDLS_ASSERT_SAME(a_mul_start_idle, clk, arst_n, mul_req_q.start, !mul_rsp.busy,
		"multiplier started while busy")
	`FDLS_ASSERT_SAME(a_div_start_idle, clk, arst_n, div_req_q.start, !div_rsp.busy,
		"divider started while busy")
	`FDLS_ASSERT_SAME(a_reject_no_freq, clk, arst_n, out_valid && status, next_freq == '0,
		"rejected item carries a frequency")

endmodule

`default_nettype wire
